// ===== src/mlcd_pkg.sv =====
package mlcd_pkg;

    localparam int SAMPLE_BITS_DEF = 12;

    localparam int COUNT_W    = 10;
    localparam int HYST_W     = 11;
    localparam int PERIOD_W   = 10;
    localparam int DHYST_W    = 8;
    localparam int LEVEL_W    = 20;
    localparam int MSQ_W      = 24;
    localparam int FACT_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [COUNT_W-1:0]  COUNT_LIMIT    = 10'd1023;
    localparam logic [COUNT_W:0]    TIMEOUT_MARGIN = 11'd2;
    localparam logic [FACT_W-1:0]   FACTOR_BASE    = 9'd200;
    // threshold scaling: divide by 200, then halve
    localparam logic [COUNT_W-1:0]  THR_DIVISOR    = 10'd400;

    localparam logic [HYST_W-1:0]   ZC_HYST_RST    = 11'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_RST     = 10'd200;
    localparam logic [DHYST_W-1:0]  DET_HYST_RST   = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZC_HYST  = 2'd0,
        REG_PERIOD   = 2'd1,
        REG_DET_HYST = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_LVL,
        S_DIV_SQ,
        S_MUL_MEAN,
        S_MUL_FACT,
        S_DIV_THR,
        S_SQUARE,
        S_OUT
    } t_state;

endpackage

// ===== src/mlcd_if.sv =====
interface mlcd_in_if #(
    parameter int SAMPLE_BITS = mlcd_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] current_sample;
    logic [SAMPLE_BITS-1:0] reference_sample;
    logic [SAMPLE_BITS-1:0] level_pot_sample;

    modport source (output valid, current_sample, reference_sample, level_pot_sample,
                    input ready);
    modport sink   (input valid, current_sample, reference_sample, level_pot_sample,
                    output ready);
endinterface

interface mlcd_out_if;
    import mlcd_pkg::*;
    logic               valid;
    logic               ready;
    logic               period_end;
    logic               load_on;
    logic [LEVEL_W-1:0] detect_level;
    logic [COUNT_W-1:0] period_length;
    logic [MSQ_W-1:0]   mean_square_current;

    modport source (output valid, period_end, load_on, detect_level, period_length,
                           mean_square_current,
                    input ready);
    modport sink   (input valid, period_end, load_on, detect_level, period_length,
                          mean_square_current,
                    output ready);
endinterface

interface mlcd_cfg_if;
    import mlcd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/mains_load_current_detector.sv =====
// A tick that does not close a period is squared by the bit-serial shift-add squarer and then
//   emitted from the emit state.
// A closing tick first runs three restoring divisions and two shift-add multiplies, in order:
//   level sum and square sum by tick count, mean squared, times the factor, divided by 400.
// The next tick is taken in the cycle after the emit, not before; the emit waits while the last
//   result is held. Sync active-low reset resets the period state and loads config defaults.
module mains_load_current_detector #(
    parameter int SAMPLE_BITS = mlcd_pkg::SAMPLE_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mlcd_cfg_if.sink   i_cfg,
    mlcd_in_if.sink    i_in,
    mlcd_out_if.source o_out
);
    import mlcd_pkg::*;

    localparam int ML     = SAMPLE_BITS - 2;          // pot value width
    localparam int LW     = ML + COUNT_W;             // level sum width
    localparam int SQ_W   = 2 * SAMPLE_BITS + COUNT_W; // square sum width
    localparam int PW     = 2 * ML + FACT_W;          // threshold product width
    localparam int DW     = SQ_W;                     // divider dividend width
    localparam int MB_W   = (SAMPLE_BITS > FACT_W) ? SAMPLE_BITS : FACT_W;
    localparam int DCNT_W = $clog2(DW + 1);
    localparam int CMP_W  = ((SAMPLE_BITS > HYST_W) ? SAMPLE_BITS : HYST_W) + 2;

    // configuration
    logic [HYST_W-1:0]   r_zc_hyst;
    logic [PERIOD_W-1:0] r_period;
    logic [DHYST_W-1:0]  r_det_hyst;

    // period state
    t_state             r_state, n_state;
    logic               r_armed;
    logic [COUNT_W-1:0] r_tick;
    logic [SQ_W-1:0]    r_sq_sum;
    logic [LW-1:0]      r_lvl_sum;
    logic [LEVEL_W-1:0] r_thr;
    logic               r_load;
    logic [COUNT_W-1:0] r_last_len;
    logic [MSQ_W-1:0]   r_last_msq;
    logic               r_ended;
    logic               r_ov;

    // serial arithmetic
    logic [DW-1:0]          r_dq, n_dq;
    logic [COUNT_W-1:0]     r_rem, n_rem;
    logic [COUNT_W-1:0]     r_dvsr;
    logic [DCNT_W-1:0]      r_dcnt;
    logic [PW-1:0]          r_ma, r_mp, n_mp;
    logic [MB_W-1:0]        r_mb;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic [ML-1:0]          r_mean;

    // output payload
    logic               r_o_end;
    logic               r_o_load;
    logic [LEVEL_W-1:0] r_o_level;
    logic [COUNT_W-1:0] r_o_len;
    logic [MSQ_W-1:0]   r_o_msq;

    // tick front end
    logic                   in_xfer;
    logic                   out_free;
    logic [SAMPLE_BITS:0]   cur;
    logic [SAMPLE_BITS:0]   mag_w;
    logic [SAMPLE_BITS-1:0] mag;
    logic signed [CMP_W-1:0] cur_x, hyst_x;
    logic [COUNT_W-1:0]     tick_n;
    logic [LW-1:0]          lvl_n;
    logic                   ended;
    logic                   armed_n;

    // division / multiply step
    logic [COUNT_W:0]   div_t;
    logic               div_ge;
    logic               div_last;
    logic               mul_last;
    logic [LEVEL_W-1:0] thr_sat;
    logic [MSQ_W-1:0]   msq_sat;
    logic [FACT_W-1:0]  factor;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_free    = !r_ov || o_out.ready;

    assign o_out.valid               = r_ov;
    assign o_out.period_end          = r_o_end;
    assign o_out.load_on             = r_o_load;
    assign o_out.detect_level        = r_o_level;
    assign o_out.period_length       = r_o_len;
    assign o_out.mean_square_current = r_o_msq;

    always_comb begin
        cur    = {1'b0, i_in.current_sample} - {1'b0, i_in.reference_sample};
        mag_w  = cur[SAMPLE_BITS] ? -cur : cur;
        mag    = mag_w[SAMPLE_BITS-1:0];
        cur_x  = {{(CMP_W-SAMPLE_BITS-1){cur[SAMPLE_BITS]}}, cur};
        hyst_x = {{(CMP_W-HYST_W){1'b0}}, r_zc_hyst};
        tick_n = r_tick + 1'b1;
        lvl_n  = r_lvl_sum + LW'(i_in.level_pot_sample[SAMPLE_BITS-1:2]);
        ended  = (r_armed && (r_zc_hyst != '0) && (cur_x > hyst_x))
              || ({1'b0, tick_n} > ({1'b0, r_period} + TIMEOUT_MARGIN))
              || (tick_n >= COUNT_LIMIT);
        if (ended) begin
            armed_n = 1'b0;
        end else if (!r_armed && (cur_x < -hyst_x)) begin
            armed_n = 1'b1;
        end else begin
            armed_n = r_armed;
        end
    end

    always_comb begin
        div_t    = {r_rem, r_dq[DW-1]};
        div_ge   = div_t >= {1'b0, r_dvsr};
        n_rem    = div_ge ? COUNT_W'(div_t - {1'b0, r_dvsr}) : div_t[COUNT_W-1:0];
        n_dq     = {r_dq[DW-2:0], div_ge};
        div_last = (r_dcnt == DCNT_W'(1));
        n_mp     = r_mb[0] ? r_mp + r_ma : r_mp;
        mul_last = (r_mb[MB_W-1:1] == '0);
        thr_sat  = (|n_dq[DW-1:LEVEL_W]) ? '1 : n_dq[LEVEL_W-1:0];
        msq_sat  = (|n_dq[DW-1:MSQ_W]) ? '1 : n_dq[MSQ_W-1:0];
        // falling threshold only once a load is seen against a live level
        if (r_load && (r_thr != '0)) begin
            factor = (r_det_hyst >= DHYST_W'(FACTOR_BASE)) ? '0
                   : FACTOR_BASE - {1'b0, r_det_hyst};
        end else begin
            factor = FACTOR_BASE + {1'b0, r_det_hyst};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (in_xfer)  n_state = ended ? S_DIV_LVL : S_SQUARE;
            S_DIV_LVL:  if (div_last) n_state = S_DIV_SQ;
            S_DIV_SQ:   if (div_last) n_state = S_MUL_MEAN;
            S_MUL_MEAN: if (mul_last) n_state = S_MUL_FACT;
            S_MUL_FACT: if (mul_last) n_state = S_DIV_THR;
            S_DIV_THR:  if (div_last) n_state = S_SQUARE;
            S_SQUARE:   if (mul_last) n_state = S_OUT;
            S_OUT:      if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zc_hyst  <= ZC_HYST_RST;
            r_period   <= PERIOD_RST;
            r_det_hyst <= DET_HYST_RST;
            r_armed    <= 1'b1;
            r_tick     <= '0;
            r_sq_sum   <= '0;
            r_lvl_sum  <= '0;
            r_thr      <= '0;
            r_load     <= 1'b0;
            r_last_len <= '0;
            r_last_msq <= '0;
            r_ended    <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_ZC_HYST:  r_zc_hyst  <= i_cfg.data[HYST_W-1:0];
                    REG_PERIOD:   r_period   <= i_cfg.data[PERIOD_W-1:0];
                    REG_DET_HYST: r_det_hyst <= i_cfg.data[DHYST_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_armed   <= armed_n;
                        r_ended   <= ended;
                        r_tick    <= ended ? '0 : tick_n;
                        r_lvl_sum <= ended ? '0 : lvl_n;
                        if (ended) begin
                            r_last_len <= tick_n;
                        end
                    end
                end
                S_DIV_LVL: begin
                    // divider copies the old sum at this transfer
                    if (div_last) begin
                        r_sq_sum <= '0;
                    end
                end
                S_DIV_SQ: begin
                    if (div_last) begin
                        r_last_msq <= msq_sat;
                    end
                end
                S_DIV_THR: begin
                    if (div_last) begin
                        r_thr  <= thr_sat;
                        r_load <= r_last_msq > MSQ_W'(thr_sat);
                    end
                end
                S_SQUARE: begin
                    if (mul_last) begin
                        r_sq_sum <= r_sq_sum + SQ_W'(n_mp);
                    end
                end
                default: ;
            endcase

            if (r_state == S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_mag <= mag;
                    if (ended) begin
                        r_dq   <= DW'(lvl_n) << (DW - LW);
                        r_rem  <= '0;
                        r_dvsr <= tick_n;
                        r_dcnt <= DCNT_W'(LW);
                    end else begin
                        r_ma <= PW'(mag);
                        r_mb <= MB_W'(mag);
                        r_mp <= '0;
                    end
                end
            end
            S_DIV_LVL, S_DIV_SQ, S_DIV_THR: begin
                if (!div_last) begin
                    r_dq   <= n_dq;
                    r_rem  <= n_rem;
                    r_dcnt <= r_dcnt - 1'b1;
                end else if (r_state == S_DIV_LVL) begin
                    r_mean <= n_dq[ML-1:0];
                    r_dq   <= r_sq_sum;
                    r_rem  <= '0;
                    r_dcnt <= DCNT_W'(DW);
                end else if (r_state == S_DIV_SQ) begin
                    r_ma <= PW'(r_mean);
                    r_mb <= MB_W'(r_mean);
                    r_mp <= '0;
                end else begin
                    r_ma <= PW'(r_mag);
                    r_mb <= MB_W'(r_mag);
                    r_mp <= '0;
                end
            end
            S_MUL_MEAN, S_MUL_FACT, S_SQUARE: begin
                if (!mul_last) begin
                    r_ma <= r_ma << 1;
                    r_mb <= r_mb >> 1;
                    r_mp <= n_mp;
                end else if (r_state == S_MUL_MEAN) begin
                    r_ma <= n_mp;
                    r_mb <= MB_W'(factor);
                    r_mp <= '0;
                end else if (r_state == S_MUL_FACT) begin
                    r_dq   <= DW'(n_mp) << (DW - PW);
                    r_rem  <= '0;
                    r_dvsr <= THR_DIVISOR;
                    r_dcnt <= DCNT_W'(PW);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_o_end   <= r_ended;
                    r_o_load  <= r_load;
                    r_o_level <= r_thr;
                    r_o_len   <= r_last_len;
                    r_o_msq   <= r_last_msq;
                end
            end
            default: ;
        endcase
    end

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state) == S_OUT)
        else $error("output valid raised outside emit state");

    a_end_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.period_end) |-> (o_out.period_length != '0))
        else $error("closed period reports zero length");

    a_load_above_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.period_end && o_out.load_on)
            |-> (o_out.mean_square_current > MSQ_W'(o_out.detect_level)))
        else $error("load_on set without mean square above level");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_MEAN || r_state == S_MUL_FACT || r_state == S_DIV_THR)
            |-> (r_sq_sum == '0))
        else $error("square sum not cleared after period close");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_LVL || r_state == S_DIV_SQ || r_state == S_DIV_THR)
            |-> (r_dcnt != '0))
        else $error("divider running with empty bit count");

endmodule
